>>> src/bgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GESTURE_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd2;

  // Threshold reset values
  localparam logic [THR_W-1:0] LONG_PRESS_RST    = 16'd800;
  localparam logic [THR_W-1:0] SINGLE_MAX_RST    = 16'd400;
  localparam logic [THR_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_PRESSED     = 3'd1,
    PH_WAIT_DOUBLE = 3'd2,
    PH_LONG_HELD   = 3'd3,
    PH_DOUBLE_HELD = 3'd4
  } phase_e;

  typedef enum logic [GESTURE_W-1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } gesture_e;

  typedef struct packed {
    logic [THR_W-1:0] long_press_ms;
    logic [THR_W-1:0] single_max_ms;
    logic [THR_W-1:0] double_window_ms;
  } bgc_cfg_t;

endpackage

>>> src/bgc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_in_if / bgc_out_if
// Valid/ready channels for button samples and gesture events.
// ----------------------------------------------------------------------------
interface bgc_in_if;
  import bgc_pkg::*;

  logic              valid;
  logic              ready;
  logic              pressed;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface bgc_out_if;
  import bgc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [GESTURE_W-1:0] gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

>>> src/button_gesture_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Sorts debounced button samples into single, double and long gestures.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  -----------------------------------
//  in_i      in   valid / ready      pressed (1b), now_ms (32b)
//  out_o     out  valid / ready      gesture (2b): none/single/double/long
//  cfg       in   cfg_we_i (no wait) cfg_idx_i (2b), cfg_data_i (16b)
//
//  Throughput is one sample per cycle while the output is not stalled; a
//  sample passes the input register and then the gesture register before
//  its gesture is valid. The path is: input register, one 32-bit subtract and
//  compare in the state machine, gesture register.
//  Reset clears the phase to idle, both timestamps to zero and loads the
//  default thresholds (800 / 400 / 300 ms).
//  A stalled output holds its gesture; the input register still drains into
//  it once taken, and in_i.ready stays high while that register can advance.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bgc_in_if.sink                       in_i,
  bgc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgc_pkg::THR_W-1:0]     cfg_data_i
);
  import bgc_pkg::*;

  bgc_cfg_t          cfg_q;

  // input request register
  logic              s1_valid_q;
  logic              s1_pressed_q;
  logic [TIME_W-1:0] s1_now_q;

  // result register
  logic              out_valid_q;
  gesture_e          gesture_q;

  gesture_e          gesture;
  logic              advance;
  logic              in_accept;

  // Advance the sample into the state machine when the result slot frees up
  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  // Threshold registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms    <= LONG_PRESS_RST;
      cfg_q.single_max_ms    <= SINGLE_MAX_RST;
      cfg_q.double_window_ms <= DOUBLE_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS:    cfg_q.long_press_ms    <= cfg_data_i;
        CFG_SINGLE_MAX:    cfg_q.single_max_ms    <= cfg_data_i;
        CFG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: valid bit under reset, payload loads on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pressed_q <= in_i.pressed;
      s1_now_q     <= in_i.now_ms;
    end
  end

  // The state machine steps exactly once per sample, as it moves to output
  bgc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pressed_i (s1_pressed_q),
    .now_ms_i  (s1_now_q),
    .cfg_i     (cfg_q),
    .gesture_o (gesture)
  );

  // Output stage: hold the gesture until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gesture_q <= gesture;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.gesture = gesture_q;

endmodule

>>> src/bgc_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_fsm
// Gesture state machine: phase, press start and release timestamps.
// ----------------------------------------------------------------------------
module bgc_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      pressed_i,
  input  logic [bgc_pkg::TIME_W-1:0] now_ms_i,
  input  bgc_pkg::bgc_cfg_t         cfg_i,
  output bgc_pkg::gesture_e         gesture_o
);
  import bgc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] release_q, release_d;
  logic [TIME_W-1:0] dt;
  logic [TIME_W-1:0] long_thr;
  logic [TIME_W-1:0] single_thr;
  logic [TIME_W-1:0] window_thr;
  gesture_e          gesture;

  assign long_thr   = {{(TIME_W-THR_W){1'b0}}, cfg_i.long_press_ms};
  assign single_thr = {{(TIME_W-THR_W){1'b0}}, cfg_i.single_max_ms};
  assign window_thr = {{(TIME_W-THR_W){1'b0}}, cfg_i.double_window_ms};

  // One subtractor serves both timers: wrap-around difference
  assign dt = now_ms_i - ((phase_q == PH_WAIT_DOUBLE) ? release_q : start_q);

  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    release_d = release_q;
    gesture   = EV_NONE;
    unique case (phase_q)
      PH_PRESSED: begin
        if (pressed_i) begin
          if (dt >= long_thr) begin
            phase_d = PH_LONG_HELD;
            gesture = EV_LONG;
          end
        end else if (dt < single_thr) begin
          phase_d   = PH_WAIT_DOUBLE;
          release_d = now_ms_i;
        end else begin
          // medium press: drop
          phase_d = PH_IDLE;
        end
      end
      PH_WAIT_DOUBLE: begin
        if (pressed_i) begin
          if (dt <= window_thr) begin
            phase_d = PH_DOUBLE_HELD;
            gesture = EV_DOUBLE;
          end else begin
            // late second press: report single, time a fresh press
            phase_d = PH_PRESSED;
            start_d = now_ms_i;
            gesture = EV_SINGLE;
          end
        end else if (dt > window_thr) begin
          phase_d = PH_IDLE;
          gesture = EV_SINGLE;
        end
      end
      PH_LONG_HELD, PH_DOUBLE_HELD: begin
        if (!pressed_i) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (pressed_i) begin
          phase_d = PH_PRESSED;
          start_d = now_ms_i;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      start_q   <= '0;
      release_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      start_q   <= start_d;
      release_q <= release_d;
    end
  end

  assign gesture_o = gesture;

  a_long_enters_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && gesture == EV_LONG |=> phase_q == PH_LONG_HELD)
    else $error("long event without long-held phase");

  a_double_enters_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && gesture == EV_DOUBLE |=> phase_q == PH_DOUBLE_HELD)
    else $error("double event without double-held phase");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(start_q) && $stable(release_q))
    else $error("state moved without a sample");

  a_release_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_PRESSED && !pressed_i
      |=> phase_q == PH_WAIT_DOUBLE || phase_q == PH_IDLE)
    else $error("bad phase after release");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button gesture classifier. A scripted run of
// press/release samples covers timestamp wrap, the exact threshold edges and
// every gesture code. Random press sequences follow under five threshold
// settings with idle gaps on both channels. Each returned gesture is compared
// in order with a typed-in value or an in-bench press state machine model.
// ----------------------------------------------------------------------------
module tb_top;
  import bgc_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned N_PHASES        = 5;
  localparam int unsigned RAND_TOTAL      = ITEMS_PER_PHASE * N_PHASES;
  localparam int unsigned HOLD_OFF_AT     = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // covers the path from accept to gesture, plus margin
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned TIMEOUT_NS      = 2_000_000;
  localparam int unsigned N_DIRECTED      = 22;
  // the index port is two bits wide; the top code selects no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [THR_W-1:0]     cfg_data_i;

  bgc_in_if  in_if ();
  bgc_out_if out_if ();

  button_gesture_classifier u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Press state model: thresholds, phase and the two timestamps
  // --------------------------------------------------------------------------
  bgc_cfg_t          thr        = '{LONG_PRESS_RST, SINGLE_MAX_RST, DOUBLE_WINDOW_RST};
  phase_e            btn_phase  = PH_IDLE;
  logic [TIME_W-1:0] press_t0   = '0;
  logic [TIME_W-1:0] release_t0 = '0;

  // Advance the press state by one sample and return the gesture it yields.
  // All elapsed times are plain 32-bit differences, so they wrap with now_ms.
  function automatic gesture_e classify_sample(input logic held,
                                               input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] dt;
    gesture_e          g;
    g = EV_NONE;
    case (btn_phase)
      PH_PRESSED: begin
        dt = t - press_t0;
        if (held) begin
          // long fires on the first held sample that reaches the threshold
          if (dt >= thr.long_press_ms) begin
            btn_phase = PH_LONG_HELD;
            g         = EV_LONG;
          end
        end else if (dt < thr.single_max_ms) begin
          btn_phase  = PH_WAIT_DOUBLE;
          release_t0 = t;
        end else begin
          // medium press: drop it silently
          btn_phase = PH_IDLE;
        end
      end
      PH_WAIT_DOUBLE: begin
        dt = t - release_t0;
        if (held && dt <= thr.double_window_ms) begin
          btn_phase = PH_DOUBLE_HELD;
          g         = EV_DOUBLE;
        end else if (held) begin
          // late second press: report the first one, time the new one
          btn_phase = PH_PRESSED;
          press_t0  = t;
          g         = EV_SINGLE;
        end else if (dt > thr.double_window_ms) begin
          btn_phase = PH_IDLE;
          g         = EV_SINGLE;
        end
      end
      PH_LONG_HELD, PH_DOUBLE_HELD: begin
        if (!held) btn_phase = PH_IDLE;
      end
      default: begin
        if (held) begin
          btn_phase = PH_PRESSED;
          press_t0  = t;
        end else begin
          btn_phase = PH_IDLE;
        end
      end
    endcase
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Expected gestures and checking
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic     known;
    gesture_e gesture;
  } typed_gesture_t;

  typed_gesture_t typed_q[$];    // per offered request: typed-in value, if any
  gesture_e       gesture_q[$];  // expected gestures, oldest first
  int unsigned    samples_sent  = 0;
  int unsigned    gestures_seen = 0;
  int unsigned    mismatch_cnt  = 0;

  function automatic void report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // Predict on every accepted sample. Scripted rows with a typed-in gesture
  // use that value; the model still advances so later rows stay in step.
  always @(posedge clk_i) begin
    typed_gesture_t note;
    gesture_e       predicted;
    if (rst_ni && in_if.valid && in_if.ready) begin
      note      = typed_q.pop_front();
      predicted = classify_sample(in_if.pressed, in_if.now_ms);
      gesture_q.push_back(note.known ? note.gesture : predicted);
    end
  end

  always @(posedge clk_i) begin
    gesture_e want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      gestures_seen++;
      if (gesture_q.size() == 0) begin
        report_mismatch($sformatf("gesture %0d #%0d with no request pending",
                                  out_if.gesture, gestures_seen));
      end else begin
        want = gesture_q.pop_front();
        if (out_if.gesture !== want) begin
          report_mismatch($sformatf("gesture #%0d: expected %0d, got %0d",
                                    gestures_seen, want, out_if.gesture));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off to back the block up
  // --------------------------------------------------------------------------
  int unsigned in_idle_pct  = 25;
  int unsigned out_idle_pct = 53;
  bit          hold_off_req = 1'b0;

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // hold ready low for HOLD_OFF_CYCLES while the sender keeps offering, so input stalls
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration
  // --------------------------------------------------------------------------
  // Offer one sample, idling first at the current rate; return at the edge
  // that accepts it, with valid still high.
  task automatic send_sample(input logic held, input logic [TIME_W-1:0] t,
                             input logic known, input gesture_e g);
    typed_gesture_t note;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    note.known   = known;
    note.gesture = g;
    typed_q.push_back(note);
    in_if.valid   <= 1'b1;
    in_if.pressed <= held;
    in_if.now_ms  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    samples_sent++;
  endtask

  // Drop valid and wait until every request has come back as a gesture.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (gestures_seen != samples_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LONG_PRESS:    thr.long_press_ms    = data;
      CFG_SINGLE_MAX:    thr.single_max_ms    = data;
      CFG_DOUBLE_WINDOW: thr.double_window_ms = data;
      default: ;
    endcase
  endtask

  task automatic write_thresholds(input logic [THR_W-1:0] long_ms,
                                  input logic [THR_W-1:0] single_ms,
                                  input logic [THR_W-1:0] window_ms);
    write_reg(CFG_LONG_PRESS, long_ms);
    write_reg(CFG_SINGLE_MAX, single_ms);
    write_reg(CFG_DOUBLE_WINDOW, window_ms);
    cfg_we_i <= 1'b0;
  endtask

  // Time step to the next sample: in 9 of 20 draws right at a threshold (one
  // below, on, one above), else a short random step, rarely an arbitrary jump.
  function automatic logic [TIME_W-1:0] pick_gap();
    logic [TIME_W-1:0] nudge;
    nudge = $urandom_range(0, 2);
    case ($urandom_range(0, 19))
      0, 1, 2:  return thr.long_press_ms + nudge - 1;
      3, 4, 5:  return thr.single_max_ms + nudge - 1;
      6, 7, 8:  return thr.double_window_ms + nudge - 1;
      19:       return $urandom;
      default:  return $urandom_range(0, 1000);
    endcase
  endfunction

  logic              btn_level = 1'b0;
  logic [TIME_W-1:0] btn_clock = '0;
  int unsigned       rand_done = 0;

  // Press/release sequences with threshold-edge timing; one sample in eight
  // is noise with an arbitrary level and timestamp.
  task automatic send_random_run(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (rand_done < RAND_TOTAL / 3) begin
        in_idle_pct  = 25;
        out_idle_pct = 53;
      end else if (rand_done < 2 * RAND_TOTAL / 3) begin
        in_idle_pct  = 53;
        out_idle_pct = 25;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (rand_done == HOLD_OFF_AT) hold_off_req = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        btn_level = 1'($urandom_range(0, 1));
        btn_clock = $urandom;
      end else begin
        if ($urandom_range(0, 1) == 1) btn_level = ~btn_level;
        btn_clock = btn_clock + pick_gap();
      end
      send_sample(btn_level, btn_clock, 1'b0, EV_NONE);
      rand_done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scripted samples under reset thresholds (800 / 400 / 300 ms)
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
    logic              known;
    gesture_e          gesture;
  } press_row_t;

  press_row_t press_script [N_DIRECTED] = '{
    '{1'b0, 32'h0000_0000, 1'b1, EV_NONE},    // released out of reset
    '{1'b1, 32'hFFFF_FF00, 1'b1, EV_NONE},    // press just before wrap
    '{1'b1, 32'h0000_0200, 1'b1, EV_NONE},    // held 768 ms across wrap
    '{1'b1, 32'h0000_0220, 1'b1, EV_LONG},    // held exactly 800 ms
    '{1'b1, 32'h0000_0240, 1'b0, EV_NONE},
    '{1'b0, 32'h0000_0300, 1'b0, EV_NONE},
    '{1'b1, 32'd1000,      1'b0, EV_NONE},    // short press, 399 ms
    '{1'b0, 32'd1399,      1'b0, EV_NONE},
    '{1'b1, 32'd1699,      1'b1, EV_DOUBLE},  // second press right at window
    '{1'b1, 32'd1800,      1'b0, EV_NONE},
    '{1'b0, 32'd1900,      1'b0, EV_NONE},
    '{1'b1, 32'd2000,      1'b0, EV_NONE},    // medium press, 400 ms
    '{1'b0, 32'd2400,      1'b1, EV_NONE},
    '{1'b1, 32'd3000,      1'b0, EV_NONE},
    '{1'b0, 32'd3100,      1'b0, EV_NONE},
    '{1'b1, 32'd3401,      1'b1, EV_SINGLE},  // late second press
    '{1'b0, 32'd3500,      1'b0, EV_NONE},
    '{1'b0, 32'd3800,      1'b1, EV_NONE},    // gap equal to window
    '{1'b0, 32'd3801,      1'b1, EV_SINGLE},  // window expiry
    '{1'b1, 32'hFFFF_FFFF, 1'b0, EV_NONE},
    '{1'b0, 32'h0000_0000, 1'b0, EV_NONE},    // release 1 ms later, wrapped
    '{1'b0, 32'hFFFF_FFFF, 1'b1, EV_SINGLE}   // time runs backward: huge gap
  };

  initial begin
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_LONG_PRESS;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.pressed <= 1'b0;
    in_if.now_ms  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (press_script[i]) begin
      send_sample(press_script[i].pressed, press_script[i].now_ms,
                  press_script[i].known, press_script[i].gesture);
    end
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: ;  // keep reset thresholds
        1: write_thresholds('0, '0, '0);
        2: write_thresholds('1, '1, '1);
        3: begin
          // a write to the spare index must not touch any threshold
          write_reg(CFG_UNUSED, THR_W'($urandom));
          write_thresholds(THR_W'($urandom_range(0, 1200)),
                           THR_W'($urandom_range(0, 1200)),
                           THR_W'($urandom_range(0, 1200)));
        end
        default: begin
          write_thresholds(THR_W'($urandom), THR_W'($urandom_range(0, 1200)),
                           THR_W'($urandom_range(0, 1200)));
        end
      endcase
      send_random_run(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> button_gesture_classifier.f
src/bgc_pkg.sv
src/bgc_if.sv
src/bgc_fsm.sv
src/button_gesture_classifier.sv
test/tb_top.sv
